@@ hw/rtl/heightmap_bilinear_sampler_defines.svh @@
// Assertion macros shared by the heightmap sampler checker
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heightmap sampler check failed");

// Next-cycle implication, disabled during reset
`define HBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heightmap sampler check failed");

`endif

@@ hw/rtl/hbs_pkg.sv @@
// Package: constants, codes and types of the heightmap sampler
`default_nettype none
package hbs_pkg;

  localparam int GRID_SIZE = 257;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int AW        = $clog2(CELLS);
  localparam int CELL_W    = $clog2(GRID_SIZE - 1);
  localparam int CELL_MAX  = GRID_SIZE - 2;

  localparam int IDX_W     = 17;
  localparam int IN_DW     = 152;
  localparam int OUT_DW    = 96;
  localparam int CFG_AW    = 3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_X   = 3'd0,
    REG_MIN_Y   = 3'd1,
    REG_MAX_X   = 3'd2,
    REG_MAX_Y   = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5
  } cfg_reg_e;

  typedef logic [3:0][AW-1:0] addr4_t;
  typedef logic [3:0][31:0]   hgt4_t;

  // Request from the pipeline to the grid memory
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    addr4_t        rd_addr;
  } mem_req_t;

  // Fields carried alongside a sample to the output
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        in_bounds;
  } pass_t;

  // Full item as captured at the input
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      hv;
    pass_t            pass;
  } item_t;

endpackage
`default_nettype wire

@@ hw/rtl/hbs_grid.sv @@
// Height grid: four copies so that all four corners are read together
`default_nettype none
module hbs_grid (
  input  wire logic              clk,
  input  wire hbs_pkg::mem_req_t req,
  output      hbs_pkg::hgt4_t    rd_data
);
  import hbs_pkg::*;

  logic [31:0] mem [4][CELLS];
  hgt4_t       rd_data_r;

  // Write every copy, read each copy at its own corner
  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (req.wr_en) begin
        mem[b][req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
        rd_data_r[b] <= mem[b][req.rd_addr[b]];
      end
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

@@ hw/rtl/heightmap_bilinear_sampler.sv @@
// Top level: bilinear heightmap sampler pipeline
// Takes one item per cycle unless a stalled output has filled the pipeline;
// the path is a nine-register pipeline (capture, bounds test, two 32x32
// coordinate products, address build, grid read, corner weighting, row blend,
// column blend and rounding). Write items update the grid at the read stage, so
// every sample sees exactly the writes accepted before it, and give no result.
// Bubbles close up under output stall, so input is taken while a result waits.
// The grid is held as four copies so the four corners read together; entries
// not yet written read as garbage.
`default_nettype none
module heightmap_bilinear_sampler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // grid_index[16:0], height_value[48:17], pos_x[80:49], pos_y[112:81],
  // pos_z[144:113], zero fill
  input  wire logic [hbs_pkg::IN_DW-1:0]      in_tdata,
  // opcode[0]
  input  wire logic                           in_tuser,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output      logic [hbs_pkg::OUT_DW-1:0]     out_tdata,
  // inside_res[0]
  output      logic                           out_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [hbs_pkg::CFG_AW-1:0]     cfg_index,
  input  wire logic [31:0]                    cfg_wdata
);
  import hbs_pkg::*;

  // Configuration registers
  logic signed [31:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic [31:0]        scale_x_r, scale_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      min_y_r   <= '0;
      max_x_r   <= '0;
      max_y_r   <= '0;
      scale_x_r <= 32'd65536;
      scale_y_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_MIN_X:   min_x_r   <= cfg_wdata;
        REG_MIN_Y:   min_y_r   <= cfg_wdata;
        REG_MAX_X:   max_x_r   <= cfg_wdata;
        REG_MAX_Y:   max_y_r   <= cfg_wdata;
        REG_SCALE_X: scale_x_r <= cfg_wdata;
        REG_SCALE_Y: scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and enables: a stage loads when empty or draining
  logic [9:1] v_r, en, vin;
  logic       op4_r;

  always_comb begin
    en[9] = !v_r[9] || out_tready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    vin    = {v_r[8:5], v_r[4] && (op4_r == OP_SAMPLE), v_r[3:1], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= 9; k++) begin
        if (en[k]) v_r[k] <= vin[k];
      end
    end
  end

  assign in_tready = en[1];

  // Stage 1: capture the item
  item_t s1_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r.op             <= in_tuser;
      s1_r.idx            <= in_tdata[16:0];
      s1_r.hv             <= in_tdata[48:17];
      s1_r.pass.x         <= in_tdata[80:49];
      s1_r.pass.y         <= in_tdata[112:81];
      s1_r.pass.z         <= in_tdata[144:113];
      s1_r.pass.in_bounds <= 1'b0;
    end
  end

  // Stage 2: bounds test and offsets from the tile edges
  item_t       s2_r;
  item_t       s2_nxt;
  logic [31:0] dx2_r, dy2_r;
  logic        inside_nxt;
  always_comb begin
    inside_nxt = ($signed(s1_r.pass.x) >= min_x_r) && ($signed(s1_r.pass.x) <= max_x_r)
              && ($signed(s1_r.pass.y) >= min_y_r) && ($signed(s1_r.pass.y) <= max_y_r);
    s2_nxt                = s1_r;
    s2_nxt.pass.in_bounds = inside_nxt;
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_r  <= s2_nxt;
      dx2_r <= s1_r.pass.x - min_x_r;
      dy2_r <= max_y_r - s1_r.pass.y;
    end
  end

  // Stage 3: scale offsets into exact Q32.32 grid coordinates
  item_t       s3_r;
  logic [63:0] cu3_r, cv3_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_r  <= s2_r;
      cu3_r <= 64'(dx2_r) * 64'(scale_x_r);
      cv3_r <= 64'(dy2_r) * 64'(scale_y_r);
    end
  end

  // Stage 4: clamp cells, split fractions, build corner addresses
  item_t             s4_r;
  addr4_t            addr4_r;
  logic [15:0]       tx4_r, ty4_r;
  logic [CELL_W-1:0] cx_nxt, cy_nxt;
  logic [AW-1:0]     base_nxt;
  always_comb begin
    cx_nxt   = (cu3_r[63:32] > 32'(CELL_MAX)) ? CELL_W'(CELL_MAX) : cu3_r[32 +: CELL_W];
    cy_nxt   = (cv3_r[63:32] > 32'(CELL_MAX)) ? CELL_W'(CELL_MAX) : cv3_r[32 +: CELL_W];
    base_nxt = AW'(cy_nxt) * AW'(GRID_SIZE) + AW'(cx_nxt);
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_r       <= s3_r;
      op4_r      <= s3_r.op;
      addr4_r[0] <= base_nxt;
      addr4_r[1] <= base_nxt + AW'(1);
      addr4_r[2] <= base_nxt + AW'(GRID_SIZE);
      addr4_r[3] <= base_nxt + AW'(GRID_SIZE + 1);
      tx4_r      <= cu3_r[31:16];
      ty4_r      <= cv3_r[31:16];
    end
  end

  // Stage 5: grid access; writes commit here in item order
  mem_req_t req;
  hgt4_t    hgt5;
  pass_t    p5_r;
  logic [15:0] tx5_r, ty5_r;
  always_comb begin
    req.wr_en   = en[5] && v_r[4] && (s4_r.op == OP_WRITE) && (s4_r.idx < IDX_W'(CELLS));
    req.wr_addr = s4_r.idx[AW-1:0];
    req.wr_data = s4_r.hv;
    req.rd_en   = en[5];
    req.rd_addr = addr4_r;
  end

  hbs_grid u_grid (
    .clk     (clk),
    .req     (req),
    .rd_data (hgt5)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5_r  <= s4_r.pass;
      tx5_r <= tx4_r;
      ty5_r <= ty4_r;
    end
  end

  // Stage 6: corner weights times heights
  logic [16:0]        wx5, wy6;
  logic signed [48:0] p6_r [4];
  pass_t              p6_r_pass;
  logic [15:0]        ty6_r;
  assign wx5 = 17'd65536 - {1'b0, tx5_r};
  always_ff @(posedge clk) begin
    if (en[6]) begin
      p6_r_pass <= p5_r;
      ty6_r     <= ty5_r;
      p6_r[0]   <= 49'($signed(hgt5[0])) * 49'($signed({1'b0, wx5}));
      p6_r[1]   <= 49'($signed(hgt5[1])) * 49'($signed({1'b0, 1'b0, tx5_r}));
      p6_r[2]   <= 49'($signed(hgt5[2])) * 49'($signed({1'b0, wx5}));
      p6_r[3]   <= 49'($signed(hgt5[3])) * 49'($signed({1'b0, 1'b0, tx5_r}));
    end
  end

  // Stage 7: row blends
  logic signed [49:0] r7_r [2];
  pass_t              p7_r;
  logic [15:0]        ty7_r;
  always_ff @(posedge clk) begin
    if (en[7]) begin
      p7_r    <= p6_r_pass;
      ty7_r   <= ty6_r;
      r7_r[0] <= 50'(p6_r[0]) + 50'(p6_r[1]);
      r7_r[1] <= 50'(p6_r[2]) + 50'(p6_r[3]);
    end
  end

  // Stage 8: column weights times row blends
  logic signed [67:0] q8_r [2];
  pass_t              p8_r;
  assign wy6 = 17'd65536 - {1'b0, ty7_r};
  always_ff @(posedge clk) begin
    if (en[8]) begin
      p8_r    <= p7_r;
      q8_r[0] <= 68'(r7_r[0]) * 68'($signed({1'b0, wy6}));
      q8_r[1] <= 68'(r7_r[1]) * 68'($signed({1'b0, 1'b0, ty7_r}));
    end
  end

  // Stage 9: sum, round half up to Q16.16, pick result
  logic signed [67:0] s_sum;
  logic [31:0]        z_nxt;
  pass_t              p9_r;
  pass_t              p9_nxt;
  assign s_sum = q8_r[0] + q8_r[1] + 68'sh80000000;
  assign z_nxt = p8_r.in_bounds ? s_sum[63:32] : p8_r.z;
  always_comb begin
    p9_nxt   = p8_r;
    p9_nxt.z = z_nxt;
  end
  always_ff @(posedge clk) begin
    if (en[9]) begin
      p9_r <= p9_nxt;
    end
  end

  assign out_tvalid = v_r[9];
  assign out_tdata  = {p9_r.z, p9_r.y, p9_r.x};
  assign out_tuser  = p9_r.in_bounds;
endmodule
`default_nettype wire

@@ hw/rtl/hbs_checker.sv @@
// Port-level checker for the heightmap sampler, bound to the top level
`default_nettype none
`include "heightmap_bilinear_sampler_defines.svh"
module hbs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [hbs_pkg::OUT_DW-1:0] out_tdata,
  input wire logic                       out_tuser
);
  // A stalled result holds
  `HBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // An empty output stage means the whole pipe can advance
  `HBS_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready)
  // A draining output stage never blocks input
  `HBS_ASSERT_NOW(a_ready_when_drain, out_tvalid && out_tready, in_tready)
endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
